FILE: sv/dhkt_pkg.sv
package dhkt_pkg;

  localparam int SLOTS        = 512;
  localparam int PAYLOAD_BITS = 32;
  localparam int QUEUE_DEPTH  = 2;

  localparam int ADDR_W   = $clog2(SLOTS);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int KEY_W    = 15;
  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [KEY_W-1:0]        key_t;
  typedef logic [OP_W-1:0]         op_t;
  typedef logic [PAYLOAD_BITS-1:0] payload_t;
  typedef logic [VALUE_W-1:0]      value_t;
  typedef logic [STATUS_W-1:0]     status_t;

  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FAIL = 2'd1;
  localparam status_t ST_FULL = 2'd2;

  // classified item as it waits between front and back
  typedef struct packed {
    op_t      op;
    key_t     key;
    addr_t    h1;
    addr_t    h2;
    payload_t value;
  } item_t;

  // one table slot as stored in the RAM
  typedef struct packed {
    logic     live;
    logic     ever;
    key_t     key;
    payload_t payload;
  } slot_t;

endpackage

FILE: sv/dhkt_ram.sv
module dhkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dhkt_front.sv
module dhkt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dhkt_pkg::op_t     op,
  input  dhkt_pkg::key_t    country_key,
  input  dhkt_pkg::value_t  entry_value,
  input  logic              clearing,
  input  logic              pop,
  output logic              busy,
  output logic              head_valid,
  output dhkt_pkg::item_t   head
);

  localparam int QP_W = (dhkt_pkg::QUEUE_DEPTH > 1) ? $clog2(dhkt_pkg::QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(dhkt_pkg::QUEUE_DEPTH + 1);

  typedef logic [QP_W-1:0] qptr_t;
  typedef logic [QC_W-1:0] qcnt_t;

  dhkt_pkg::item_t q [dhkt_pkg::QUEUE_DEPTH];
  qptr_t           wr_ptr;
  qptr_t           rd_ptr;
  qcnt_t           fill;
  logic            accept;
  dhkt_pkg::item_t item;

  assign busy       = clearing || (fill == qcnt_t'(dhkt_pkg::QUEUE_DEPTH));
  assign accept     = start && !busy;
  assign head_valid = (fill != '0);
  assign head       = q[rd_ptr];

  // unused op code behaves as a lookup
  always_comb begin
    item.key   = country_key;
    item.h1    = dhkt_pkg::addr_t'(country_key);
    item.h2    = dhkt_pkg::addr_t'(country_key >> dhkt_pkg::ADDR_W) | dhkt_pkg::addr_t'(1);
    item.value = dhkt_pkg::payload_t'(entry_value);
    if (op == dhkt_pkg::OP_INSERT) begin
      item.op = dhkt_pkg::OP_INSERT;
    end else if (op == dhkt_pkg::OP_REMOVE) begin
      item.op = dhkt_pkg::OP_REMOVE;
    end else begin
      item.op = dhkt_pkg::OP_LOOKUP;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == qptr_t'(dhkt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + qptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == qptr_t'(dhkt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + qptr_t'(1);
      end
      if (accept && !pop) begin
        fill <= fill + qcnt_t'(1);
      end else if (pop && !accept) begin
        fill <= fill - qcnt_t'(1);
      end
    end
  end

endmodule

FILE: sv/dhkt_back.sv
module dhkt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  dhkt_pkg::item_t     head,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output dhkt_pkg::status_t   status,
  output dhkt_pkg::addr_t     slot_index,
  output dhkt_pkg::cnt_t      probe_count,
  output dhkt_pkg::value_t    found_value,
  output dhkt_pkg::cnt_t      entry_count
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;

  localparam dhkt_pkg::cnt_t  SLOTS_CNT = dhkt_pkg::cnt_t'(dhkt_pkg::SLOTS);
  localparam dhkt_pkg::addr_t LAST_ADDR = dhkt_pkg::addr_t'(dhkt_pkg::SLOTS - 1);

  logic [1:0]        state, state_next;
  dhkt_pkg::addr_t   clr_addr, clr_addr_next;
  dhkt_pkg::item_t   cur, cur_next;
  dhkt_pkg::addr_t   pos_issue, pos_issue_next;
  dhkt_pkg::cnt_t    issued, issued_next;
  logic              pend, pend_next;
  dhkt_pkg::addr_t   pos_data, pos_data_next;
  dhkt_pkg::cnt_t    cnt_data, cnt_data_next;
  logic              free_ok, free_ok_next;
  dhkt_pkg::addr_t   free_pos, free_pos_next;
  dhkt_pkg::cnt_t    free_cnt, free_cnt_next;
  dhkt_pkg::cnt_t    live_count, live_count_next;
  logic              done_next;
  dhkt_pkg::status_t status_next;
  dhkt_pkg::addr_t   slot_index_next;
  dhkt_pkg::cnt_t    probe_count_next;
  dhkt_pkg::value_t  found_value_next;

  logic              we, re;
  dhkt_pkg::addr_t   waddr;
  dhkt_pkg::slot_t   wdata, rd;
  logic              hit, never, last, stop;
  dhkt_pkg::addr_t   fa;
  dhkt_pkg::cnt_t    fc;

  dhkt_ram #(
    .WIDTH($bits(dhkt_pkg::slot_t)),
    .DEPTH(dhkt_pkg::SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(pos_issue),
    .rdata(rd)
  );

  assign clearing    = (state == S_CLEAR);
  assign entry_count = live_count;

  assign hit   = rd.live && (rd.key == cur.key);
  assign never = !rd.ever;
  assign last  = (cnt_data == SLOTS_CNT);
  assign stop  = hit || never || last;
  assign fa    = free_ok ? free_pos : pos_data;
  assign fc    = free_ok ? free_cnt : cnt_data;

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    cur_next         = cur;
    pos_issue_next   = pos_issue;
    issued_next      = issued;
    pend_next        = pend;
    pos_data_next    = pos_data;
    cnt_data_next    = cnt_data;
    free_ok_next     = free_ok;
    free_pos_next    = free_pos;
    free_cnt_next    = free_cnt;
    live_count_next  = live_count;
    done_next        = 1'b0;
    status_next      = status;
    slot_index_next  = slot_index;
    probe_count_next = probe_count;
    found_value_next = found_value;
    pop              = 1'b0;
    we               = 1'b0;
    re               = 1'b0;
    waddr            = '0;
    wdata            = '0;

    case (state)
      S_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        clr_addr_next = clr_addr + dhkt_pkg::addr_t'(1);
        if (clr_addr == LAST_ADDR) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          pop            = 1'b1;
          cur_next       = head;
          pos_issue_next = head.h1;
          issued_next    = '0;
          pend_next      = 1'b0;
          free_ok_next   = 1'b0;
          state_next     = S_PROBE;
        end
      end
      S_PROBE: begin
        // reads run one slot ahead of the evaluation; overshoot is dropped
        if (issued != SLOTS_CNT) begin
          re             = 1'b1;
          pos_issue_next = pos_issue + cur.h2;
          issued_next    = issued + dhkt_pkg::cnt_t'(1);
          pend_next      = 1'b1;
          pos_data_next  = pos_issue;
          cnt_data_next  = issued + dhkt_pkg::cnt_t'(1);
        end else begin
          pend_next = 1'b0;
        end
        if (pend) begin
          // first non-live slot on the path is where an insert lands
          if (!rd.live && !free_ok) begin
            free_ok_next  = 1'b1;
            free_pos_next = pos_data;
            free_cnt_next = cnt_data;
          end
          if (stop) begin
            state_next       = S_IDLE;
            done_next        = 1'b1;
            status_next      = dhkt_pkg::ST_FAIL;
            slot_index_next  = '0;
            probe_count_next = cnt_data;
            found_value_next = '0;
            case (cur.op)
              dhkt_pkg::OP_INSERT: begin
                if (hit) begin
                  status_next = dhkt_pkg::ST_FAIL;
                end else if (free_ok || !rd.live) begin
                  we               = 1'b1;
                  waddr            = fa;
                  wdata.live       = 1'b1;
                  wdata.ever       = 1'b1;
                  wdata.key        = cur.key;
                  wdata.payload    = cur.value;
                  status_next      = dhkt_pkg::ST_OK;
                  slot_index_next  = fa;
                  probe_count_next = fc;
                  live_count_next  = live_count + dhkt_pkg::cnt_t'(1);
                end else begin
                  status_next      = dhkt_pkg::ST_FULL;
                  probe_count_next = SLOTS_CNT;
                end
              end
              dhkt_pkg::OP_REMOVE: begin
                if (hit) begin
                  we              = 1'b1;
                  waddr           = pos_data;
                  wdata           = rd;
                  wdata.live      = 1'b0;
                  status_next     = dhkt_pkg::ST_OK;
                  slot_index_next = pos_data;
                  live_count_next = live_count - dhkt_pkg::cnt_t'(1);
                end
              end
              default: begin
                if (hit) begin
                  status_next      = dhkt_pkg::ST_OK;
                  slot_index_next  = pos_data;
                  found_value_next = dhkt_pkg::value_t'(rd.payload);
                end
              end
            endcase
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      pend       <= 1'b0;
      done       <= 1'b0;
      live_count <= '0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      pend       <= pend_next;
      done       <= done_next;
      live_count <= live_count_next;
    end
  end

  always_ff @(posedge clk) begin
    cur         <= cur_next;
    pos_issue   <= pos_issue_next;
    issued      <= issued_next;
    pos_data    <= pos_data_next;
    cnt_data    <= cnt_data_next;
    free_ok     <= free_ok_next;
    free_pos    <= free_pos_next;
    free_cnt    <= free_cnt_next;
    status      <= status_next;
    slot_index  <= slot_index_next;
    probe_count <= probe_count_next;
    found_value <= found_value_next;
  end

  a_done_after_probe: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_PROBE)
    else $error("result without a probe walk");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= SLOTS_CNT)
    else $error("live count above table size");

  a_full_means_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == dhkt_pkg::ST_FULL) |-> live_count == SLOTS_CNT)
    else $error("table full reported with free slots");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (probe_count != '0) && (probe_count <= SLOTS_CNT))
    else $error("probe count out of range");

endmodule

FILE: sv/double_hash_key_table_unit.sv
// Open-addressed key table of 512 slots with double hashing. An item is taken
// when start is high and busy is low; its one result appears for a single cycle
// with done high and cannot be held off. After reset, busy stays high while
// the slot RAM is swept clear. Items go through a two-entry queue into the
// probe engine, which reads one slot per cycle from a single RAM read port:
// an item is first loaded from the queue, then each slot read is evaluated
// once the registered RAM read returns. An insert decides duplicate and
// placement in one walk; the table write happens in the cycle the result
// is decided.
module double_hash_key_table_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  dhkt_pkg::op_t       op,
  input  dhkt_pkg::key_t      country_key,
  input  dhkt_pkg::value_t    entry_value,
  output logic                busy,
  output logic                done,
  output dhkt_pkg::status_t   status,
  output dhkt_pkg::addr_t     slot_index,
  output dhkt_pkg::cnt_t      probe_count,
  output dhkt_pkg::value_t    found_value,
  output dhkt_pkg::cnt_t      entry_count
);

  logic            clearing;
  logic            pop;
  logic            head_valid;
  dhkt_pkg::item_t head;

  dhkt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .country_key(country_key),
    .entry_value(entry_value),
    .clearing   (clearing),
    .pop        (pop),
    .busy       (busy),
    .head_valid (head_valid),
    .head       (head)
  );

  dhkt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .clearing   (clearing),
    .done       (done),
    .status     (status),
    .slot_index (slot_index),
    .probe_count(probe_count),
    .found_value(found_value),
    .entry_count(entry_count)
  );

endmodule
